// ----- rtl/core/small_set_membership_table_defines.svh -----
// assertion macros for the small set membership table
// no dependencies; included by the top level only
`ifndef SMALL_SET_MEMBERSHIP_TABLE_DEFINES_SVH
`define SMALL_SET_MEMBERSHIP_TABLE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SMST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SMST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/smst_pkg.sv -----
// shared types for the small set membership table
// used by smst_cell and small_set_membership_table; no dependencies
package smst_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic compare;
        logic do_clear;
        logic do_insert;
        logic do_delete;
    } t_cell_ctl;

endpackage

// ----- rtl/core/small_set_membership_table.sv -----
// small set membership table: a chain of entry cells with a short sequencer
// depends on smst_pkg, smst_cell and small_set_membership_table_defines.svh
//
//  channel   direction  handshake               fields
//  command   in         start high, busy low    i_cmd, i_elem
//  result    out        o_result_valid strobe   o_was_member, o_refused, o_set_count,
//                                               o_set_empty, o_set_full
//
// a command takes 2 cycles: one for the compare across all cells, one to apply
// the update (append, shift-down or clear); a new command may be taken in the
// apply cycle, so commands issue every 2 cycles
// the result strobe comes one cycle after the apply cycle
// reset empties the set; the receiver cannot stall the result
`include "small_set_membership_table_defines.svh"

module small_set_membership_table #(
    parameter int CAPACITY   = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  smst_pkg::t_cmd i_cmd,
    input  logic [31:0]  i_elem,
    output logic         o_result_valid,
    output logic         o_was_member,
    output logic         o_refused,
    output logic [4:0]   o_set_count,
    output logic         o_set_empty,
    output logic         o_set_full
);
    import smst_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_APPLY  = 3'b100
    } t_state;

    t_state                r_state, n_state;
    t_cmd                  r_cmd;
    logic [ELEM_WIDTH-1:0] r_key;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_result_valid;
    logic                  r_was_member, n_was_member;
    logic                  r_refused, n_refused;
    logic [4:0]            r_set_count;
    logic                  r_set_empty, r_set_full;

    logic                  w_accept;
    logic                  w_found;
    logic                  w_full;
    t_cell_ctl             w_ctl;

    logic [ELEM_WIDTH-1:0] w_val [CAPACITY];
    logic [CAPACITY-1:0]   w_occ;
    logic [CAPACITY-1:0]   w_hit;
    logic [CAPACITY-1:0]   w_after;

    assign busy     = (r_state == ST_SEARCH);
    assign w_accept = start && !busy;
    assign w_found  = |w_hit;
    assign w_full   = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (start) n_state = ST_SEARCH;
            ST_SEARCH: n_state = ST_APPLY;
            ST_APPLY:  n_state = start ? ST_SEARCH : ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_ctl           = '0;
        w_ctl.compare   = (r_state == ST_SEARCH);
        n_count         = r_count;
        n_was_member    = 1'b0;
        n_refused       = 1'b0;
        if (r_state == ST_APPLY) begin
            unique case (r_cmd)
                CMD_CLEAR: begin
                    w_ctl.do_clear = 1'b1;
                    n_count        = '0;
                end
                CMD_INSERT: begin
                    n_was_member = w_found;
                    if (!w_found) begin
                        if (w_full) begin
                            n_refused = 1'b1;
                        end else begin
                            w_ctl.do_insert = 1'b1;
                            n_count         = r_count + CNT_W'(1);
                        end
                    end
                end
                CMD_DELETE: begin
                    n_was_member = w_found;
                    if (w_found) begin
                        w_ctl.do_delete = 1'b1;
                        n_count         = r_count - CNT_W'(1);
                    end
                end
                CMD_QUERY: n_was_member = w_found;
                default:   n_was_member = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_count        <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_count        <= n_count;
            r_result_valid <= (r_state == ST_APPLY);
        end
    end

    // command transfer and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
            r_key <= ELEM_WIDTH'({{32{i_elem[31]}}, i_elem});
        end
        if (r_state == ST_APPLY) begin
            r_was_member <= n_was_member;
            r_refused    <= n_refused;
            r_set_count  <= 5'(n_count);
            r_set_empty  <= (n_count == '0);
            r_set_full   <= (n_count == CNT_W'(CAPACITY));
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                  w_left_occ;
        logic                  w_left_after;
        logic [ELEM_WIDTH-1:0] w_right_val;
        logic                  w_right_occ;

        if (g == 0) begin : g_first
            assign w_left_occ   = 1'b1;
            assign w_left_after = 1'b0;
        end else begin : g_mid
            assign w_left_occ   = w_occ[g-1];
            assign w_left_after = w_after[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_val = w_val[g];
            assign w_right_occ = 1'b0;
        end else begin : g_inner
            assign w_right_val = w_val[g+1];
            assign w_right_occ = w_occ[g+1];
        end

        smst_cell #(
            .ELEM_WIDTH (ELEM_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_key        (r_key),
            .i_left_occ   (w_left_occ),
            .i_left_after (w_left_after),
            .i_right_val  (w_right_val),
            .i_right_occ  (w_right_occ),
            .o_val        (w_val[g]),
            .o_occ        (w_occ[g]),
            .o_hit        (w_hit[g]),
            .o_after      (w_after[g])
        );
    end

    assign o_result_valid = r_result_valid;
    assign o_was_member   = r_was_member;
    assign o_refused      = r_refused;
    assign o_set_count    = r_set_count;
    assign o_set_empty    = r_set_empty;
    assign o_set_full     = r_set_full;

    `SMST_ASSERT_NEXT(a_apply_gives_result, r_state == ST_APPLY, o_result_valid,
        "apply cycle not followed by a result")
    `SMST_ASSERT_NOW(a_occ_matches_count, 1'b1, $countones(w_occ) == int'(r_count),
        "cell occupancy disagrees with the count")
    `SMST_ASSERT_NOW(a_count_in_range, 1'b1, int'(r_count) <= CAPACITY,
        "count above capacity")
    `SMST_ASSERT_NOW(a_refused_only_full, o_result_valid && o_refused, o_set_full,
        "refused insert reported with room left")

endmodule

// ----- rtl/core/smst_cell.sv -----
// one entry of the set: value, occupancy, compare and shift-down step
// depends on smst_pkg
module smst_cell #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  smst_pkg::t_cell_ctl    i_ctl,
    input  logic [ELEM_WIDTH-1:0]  i_key,
    input  logic                   i_left_occ,
    input  logic                   i_left_after,
    input  logic [ELEM_WIDTH-1:0]  i_right_val,
    input  logic                   i_right_occ,
    output logic [ELEM_WIDTH-1:0]  o_val,
    output logic                   o_occ,
    output logic                   o_hit,
    output logic                   o_after
);
    import smst_pkg::*;

    logic [ELEM_WIDTH-1:0] r_val;
    logic                  r_occ;
    logic                  r_hit;
    logic                  r_after;
    logic                  w_match;

    assign w_match = r_occ && (r_val == i_key);
    // at or beyond the matching entry, handed on to the right neighbour
    assign o_after = i_left_after | w_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= 1'b0;
            r_hit   <= 1'b0;
            r_after <= 1'b0;
        end else begin
            if (i_ctl.compare) begin
                r_hit   <= w_match;
                r_after <= o_after;
            end
            if (i_ctl.do_clear) begin
                r_occ <= 1'b0;
            end else if (i_ctl.do_insert) begin
                // first free slot takes the new value
                if (!r_occ && i_left_occ) begin
                    r_occ <= 1'b1;
                end
            end else if (i_ctl.do_delete) begin
                if (r_after) begin
                    r_occ <= i_right_occ;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.do_insert && !r_occ && i_left_occ) begin
            r_val <= i_key;
        end else if (i_ctl.do_delete && r_after) begin
            r_val <= i_right_val;
        end
    end

    assign o_val = r_val;
    assign o_occ = r_occ;
    assign o_hit = r_hit;

endmodule

// ----- sim/small_set_membership_table_tb.sv -----
// self-checking testbench for the small set membership table
// depends on smst_pkg and small_set_membership_table; predicts each result in a scoreboard class
`timescale 1ns / 100ps

module small_set_membership_table_tb;
    import smst_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int ELEM_WIDTH  = 32;
    localparam int POOL_SIZE   = 24;
    localparam int PHASE_ITEMS = 205;
    localparam int QUIET_LIMIT = 1000;
    localparam int TAIL_CYCLES = 6;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_cmd        i_cmd = CMD_CLEAR;
    logic [31:0] i_elem = '0;
    logic        o_result_valid;
    logic        o_was_member;
    logic        o_refused;
    logic [4:0]  o_set_count;
    logic        o_set_empty;
    logic        o_set_full;

    small_set_membership_table #(
        .CAPACITY   (CAPACITY),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_elem         (i_elem),
        .o_result_valid (o_result_valid),
        .o_was_member   (o_was_member),
        .o_refused      (o_refused),
        .o_set_count    (o_set_count),
        .o_set_empty    (o_set_empty),
        .o_set_full     (o_set_full)
    );

    always #10 i_clk = ~i_clk;

    class set_scoreboard;
        typedef struct packed {
            logic       was_member;
            logic       refused;
            logic [4:0] count;
            logic       empty;
            logic       full;
        } t_outcome;

        logic [ELEM_WIDTH-1:0] members[CAPACITY];
        int                    member_total;
        t_outcome              outcomes_due[$];
        int                    errors;
        int                    results_seen;

        function new();
            member_total = 0;
            errors       = 0;
            results_seen = 0;
        endfunction

        task report(input string what);
            $display("mismatch at result %0d: %s", results_seen, what);
            errors++;
        endtask

        // work out the outcome of one accepted command and update the set copy
        function void note_command(input t_cmd c, input logic [31:0] e);
            t_outcome o;
            int slot;
            o = '0;
            slot = -1;
            if (c != CMD_CLEAR) begin
                for (int i = 0; i < member_total; i++) begin
                    if (slot < 0 && members[i] == e[ELEM_WIDTH-1:0]) slot = i;
                end
            end
            o.was_member = (slot >= 0);
            case (c)
                CMD_CLEAR: begin
                    member_total = 0;
                end
                CMD_INSERT: begin
                    if (slot < 0) begin
                        if (member_total == CAPACITY) begin
                            o.refused = 1'b1;
                        end else begin
                            members[member_total] = e[ELEM_WIDTH-1:0];
                            member_total++;
                        end
                    end
                end
                CMD_DELETE: begin
                    if (slot >= 0) begin
                        // close the gap
                        for (int i = slot; i < member_total - 1; i++) members[i] = members[i + 1];
                        member_total--;
                    end
                end
                default: begin
                end
            endcase
            o.count = member_total[4:0];
            o.empty = (member_total == 0);
            o.full  = (member_total == CAPACITY);
            outcomes_due.push_back(o);
        endfunction

        task check_result(input logic was_member, input logic refused, input logic [4:0] count,
                          input logic empty, input logic full);
            t_outcome o;
            results_seen++;
            if (outcomes_due.size() == 0) begin
                report("result with no command outstanding");
            end else begin
                o = outcomes_due.pop_front();
                if (was_member !== o.was_member)
                    report($sformatf("was_member %b, expected %b", was_member, o.was_member));
                if (refused !== o.refused)
                    report($sformatf("refused %b, expected %b", refused, o.refused));
                if (count !== o.count)
                    report($sformatf("set_count %0d, expected %0d", count, o.count));
                if (empty !== o.empty)
                    report($sformatf("set_empty %b, expected %b", empty, o.empty));
                if (full !== o.full)
                    report($sformatf("set_full %b, expected %b", full, o.full));
            end
        endtask
    endclass

    set_scoreboard sb = new();
    int            idle_pct = 0;
    int            quiet_cycles = 0;
    logic [31:0]   value_pool[POOL_SIZE];

    // observe both sides: results first, then any command transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid)
                sb.check_result(o_was_member, o_refused, o_set_count, o_set_empty, o_set_full);
            if (start && !busy)
                sb.note_command(i_cmd, i_elem);
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // present one command, with a random idle gap first, and wait for its transfer
    task automatic issue(input t_cmd c, input logic [31:0] e);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_cmd  <= c;
        i_elem <= e;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.outcomes_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_phase(input int items);
        int   r;
        int   ins_top;
        int   del_top;
        int   clr_top;
        t_cmd c;
        for (int n = 0; n < items; n++) begin
            // alternate between filling and draining stretches
            if ((n / 40) % 2 == 0) begin
                clr_top = 1; ins_top = 60; del_top = 75;
            end else begin
                clr_top = 2; ins_top = 22; del_top = 72;
            end
            r = $urandom_range(99);
            if (r < clr_top)
                c = CMD_CLEAR;
            else if (r < ins_top)
                c = CMD_INSERT;
            else if (r < del_top)
                c = CMD_DELETE;
            else
                c = CMD_QUERY;
            if ($urandom_range(99) < 85)
                issue(c, value_pool[$urandom_range(POOL_SIZE - 1)]);
            else
                issue(c, $urandom);
        end
    endtask

    initial begin
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty set, extreme values, duplicates, full set
        issue(CMD_CLEAR, 32'h1234_5678);
        issue(CMD_QUERY, 32'h0000_0000);
        issue(CMD_DELETE, 32'hffff_ffff);
        issue(CMD_INSERT, 32'h8000_0000);
        issue(CMD_INSERT, 32'h7fff_ffff);
        issue(CMD_INSERT, 32'h0000_0000);
        issue(CMD_INSERT, 32'hffff_ffff);
        issue(CMD_INSERT, 32'h7fff_ffff);
        issue(CMD_QUERY, 32'h8000_0000);
        issue(CMD_QUERY, 32'h0000_0001);
        issue(CMD_DELETE, 32'h7fff_ffff);
        issue(CMD_DELETE, 32'h5555_aaaa);
        for (int i = 0; i < CAPACITY - 3; i++) issue(CMD_INSERT, 32'h1000_0000 | i);
        issue(CMD_INSERT, 32'haaaa_5555);
        issue(CMD_INSERT, 32'h0000_0000);
        issue(CMD_DELETE, 32'h8000_0000);
        issue(CMD_QUERY, 32'hffff_ffff);
        issue(CMD_CLEAR, 32'hffff_ffff);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            case (p)
                1:       idle_pct = 88;
                2:       idle_pct = 10;
                default: idle_pct = 0;
            endcase
            random_phase(PHASE_ITEMS);
            // hold off until every outstanding result has been seen
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- small_set_membership_table.f -----
+incdir+rtl/core
rtl/core/smst_pkg.sv
rtl/core/smst_cell.sv
rtl/core/small_set_membership_table.sv
sim/small_set_membership_table_tb.sv
